### hw/rtl/rsd_pkg.sv
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared types and constants of the run-length sprite row decoder.
// ----------------------------------------------------------------------------
package rsd_pkg;

  localparam int BYTE_W     = 8;
  localparam int ADDR_W     = 16;
  localparam int DIM_REG_W  = 7;
  localparam int STRIDE_W   = 11;
  localparam int RUN_W      = 7;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  localparam logic [5:0] COUNT_MASK = 6'h3F;

  localparam logic [DIM_REG_W-1:0] WIDTH_RST  = 7'd64;
  localparam logic [DIM_REG_W-1:0] HEIGHT_RST = 7'd64;
  localparam logic [STRIDE_W-1:0]  STRIDE_RST = 11'd64;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_ROW_STRIDE   = 2'd2;

  typedef enum logic [1:0] {
    MODE_FILL    = 2'b00,
    MODE_SPARSE  = 2'b01,
    MODE_LITERAL = 2'b10,
    MODE_SKIP    = 2'b11
  } mode_t;

  typedef enum logic [1:0] {
    PH_OPCODE  = 2'd0,
    PH_COLOUR  = 2'd1,
    PH_LITERAL = 2'd2
  } phase_t;

  typedef struct packed {
    logic load_in;  // capture the accepted input byte
    logic prep;     // apply start-of-image and row/image end checks
    logic exec;     // decode one step and load the output register
  } dp_cmd_t;

  typedef struct packed {
    logic step_last;  // current step gives the final result of the byte
  } dp_sts_t;

endpackage

### hw/rtl/rsd_cfg.sv
// ----------------------------------------------------------------------------
// rsd_cfg
// APB register file: image width, image height and row stride, with the
// effective (clamped) dimensions used by the decoder.
// ----------------------------------------------------------------------------
module rsd_cfg #(
  parameter int MAX_DIM = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rsd_pkg::PADDR_W-1:0]   paddr,
  input  logic [rsd_pkg::PDATA_W-1:0]   pwdata,
  output logic [rsd_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output logic [$clog2(MAX_DIM+1)-1:0]  img_w,
  output logic [$clog2(MAX_DIM+1)-1:0]  img_h,
  output logic [rsd_pkg::STRIDE_W-1:0]  stride
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);

  logic [rsd_pkg::DIM_REG_W-1:0] width_reg;
  logic [rsd_pkg::DIM_REG_W-1:0] height_reg;
  logic [rsd_pkg::STRIDE_W-1:0]  stride_reg;
  logic                          wr_en;
  int                            w_eff;
  int                            h_eff;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= rsd_pkg::WIDTH_RST;
      height_reg <= rsd_pkg::HEIGHT_RST;
      stride_reg <= rsd_pkg::STRIDE_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        rsd_pkg::REG_IMAGE_WIDTH:  width_reg  <= pwdata[rsd_pkg::DIM_REG_W-1:0];
        rsd_pkg::REG_IMAGE_HEIGHT: height_reg <= pwdata[rsd_pkg::DIM_REG_W-1:0];
        rsd_pkg::REG_ROW_STRIDE:   stride_reg <= pwdata[rsd_pkg::STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      rsd_pkg::REG_IMAGE_WIDTH:  prdata = rsd_pkg::PDATA_W'(width_reg);
      rsd_pkg::REG_IMAGE_HEIGHT: prdata = rsd_pkg::PDATA_W'(height_reg);
      rsd_pkg::REG_ROW_STRIDE:   prdata = rsd_pkg::PDATA_W'(stride_reg);
      default:                   prdata = '0;
    endcase
  end

  // zero acts as one, anything above MAX_DIM acts as MAX_DIM
  always_comb begin
    w_eff = int'(width_reg);
    h_eff = int'(height_reg);
    if (w_eff == 0) w_eff = 1;
    else if (w_eff > MAX_DIM) w_eff = MAX_DIM;
    if (h_eff == 0) h_eff = 1;
    else if (h_eff > MAX_DIM) h_eff = MAX_DIM;
  end

  assign img_w  = DIM_W'(w_eff);
  assign img_h  = DIM_W'(h_eff);
  assign stride = stride_reg;

endmodule

### hw/rtl/rsd_ctrl.sv
// ----------------------------------------------------------------------------
// rsd_ctrl
// Sequencer: input holding flag, output register valid and the two-state
// prepare/execute machine that drives the datapath.
// ----------------------------------------------------------------------------
module rsd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output rsd_pkg::dp_cmd_t cmd,
  input  rsd_pkg::dp_sts_t sts
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;
  logic   in_full;
  logic   out_valid;
  logic   slot_free;
  logic   exec_go;
  logic   finish;
  logic   in_take;

  assign slot_free = ~out_valid | m_tready;
  assign exec_go   = (state == S_EXEC) & slot_free;
  assign finish    = exec_go & sts.step_last;
  assign s_tready  = ~in_full | finish;
  assign in_take   = s_tvalid & s_tready;
  assign m_tvalid  = out_valid;

  assign cmd.load_in = in_take;
  assign cmd.prep    = (state == S_IDLE) & in_full;
  assign cmd.exec    = exec_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_full   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_full) state <= S_EXEC;
        end
        S_EXEC: begin
          if (finish) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase

      if (in_take) in_full <= 1'b1;
      else if (finish) in_full <= 1'b0;

      if (exec_go) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

endmodule

### hw/rtl/rsd_dp.sv
// ----------------------------------------------------------------------------
// rsd_dp
// Decoder datapath: input byte register, cursor and run state, step decode
// and the output register with the write address multiply.
// ----------------------------------------------------------------------------
module rsd_dp #(
  parameter int MAX_DIM = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rsd_pkg::dp_cmd_t              cmd,
  output rsd_pkg::dp_sts_t              sts,
  input  logic [rsd_pkg::BYTE_W-1:0]    byte_in,
  input  logic                          start_of_image,
  input  logic [$clog2(MAX_DIM+1)-1:0]  img_w,
  input  logic [$clog2(MAX_DIM+1)-1:0]  img_h,
  input  logic [rsd_pkg::STRIDE_W-1:0]  stride,
  output logic                          write_valid,
  output logic [rsd_pkg::ADDR_W-1:0]    pixel_address,
  output logic [rsd_pkg::BYTE_W-1:0]    pixel_value,
  output logic                          image_done,
  output logic                          last_of_run
);

  localparam int ROW_W = $clog2(MAX_DIM + 2);
  localparam int COL_W = $clog2(MAX_DIM + 65);
  localparam int SUM_W = $clog2(MAX_DIM + 129);
  localparam int RUN_W = rsd_pkg::RUN_W;

  // held input byte
  logic [rsd_pkg::BYTE_W-1:0] in_byte;
  logic                       in_soi;

  // decoder state
  rsd_pkg::phase_t  phase;
  rsd_pkg::mode_t   run_mode;
  logic [RUN_W-1:0] run_rem;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic             done;

  // prepare step
  rsd_pkg::phase_t  p_phase;
  rsd_pkg::mode_t   p_mode;
  logic [RUN_W-1:0] p_rem;
  logic [COL_W-1:0] p_col;
  logic [ROW_W-1:0] p_row;
  logic             p_done;

  // execute step
  rsd_pkg::phase_t  n_phase;
  rsd_pkg::mode_t   n_mode;
  logic [RUN_W-1:0] n_rem;
  logic [COL_W-1:0] n_col;
  logic [ROW_W-1:0] n_row;
  logic             n_done;
  logic [ROW_W-1:0] row_inc;
  logic [COL_W-1:0] ce;
  logic [COL_W-1:0] colstep;
  logic [COL_W-1:0] next_ce;
  logic [COL_W-1:0] skip_sum;
  logic [SUM_W-1:0] run_span;
  logic [RUN_W-1:0] rem1;
  logic [RUN_W-1:0] count;
  logic             sparse;
  logic             colour_step;
  logic             er;
  logic             e_write;
  logic [COL_W-1:0] e_col;
  logic             e_last;
  logic             e_done;
  logic             run_done_pred;
  logic [31:0]      addr_full;

  always_comb begin
    p_phase = phase;
    p_mode  = run_mode;
    p_rem   = run_rem;
    p_col   = col;
    p_row   = row;
    p_done  = done;
    if (in_soi) begin
      p_phase = rsd_pkg::PH_OPCODE;
      p_mode  = rsd_pkg::MODE_FILL;
      p_rem   = '0;
      p_col   = '0;
      p_row   = '0;
      p_done  = 1'b0;
    end
    // height lowered under the current row
    if (!p_done && p_row >= ROW_W'(img_h)) begin
      p_row  = ROW_W'(img_h);
      p_done = 1'b1;
    end
    // width lowered under the current column: end the row, drop the run
    if (!p_done && p_col >= COL_W'(img_w)) begin
      p_col   = '0;
      p_phase = rsd_pkg::PH_OPCODE;
      p_rem   = '0;
      if (p_row + ROW_W'(1) >= ROW_W'(img_h)) begin
        p_row  = ROW_W'(img_h);
        p_done = 1'b1;
      end else begin
        p_row = p_row + ROW_W'(1);
      end
    end
  end

  always_comb begin
    n_phase     = phase;
    n_mode      = run_mode;
    n_rem       = run_rem;
    n_col       = col;
    n_row       = row;
    n_done      = done;
    er          = 1'b0;
    e_write     = 1'b0;
    e_col       = col;
    e_last      = 1'b1;
    colour_step = 1'b0;

    sparse   = (run_mode == rsd_pkg::MODE_SPARSE);
    row_inc  = row + ROW_W'(1);
    ce       = sparse ? col + COL_W'(1) : col;
    colstep  = ce + COL_W'(1);
    next_ce  = sparse ? colstep + COL_W'(1) : colstep;
    rem1     = run_rem - RUN_W'(1);
    count    = RUN_W'(in_byte[5:0] & rsd_pkg::COUNT_MASK) + RUN_W'(1);
    skip_sum = col + COL_W'(count);
    // column plus the columns still to cover stays fixed through a run
    run_span = SUM_W'(col) + (sparse ? SUM_W'({run_rem, 1'b0}) : SUM_W'(run_rem));
    run_done_pred = (run_span >= SUM_W'(img_w)) && (row_inc >= ROW_W'(img_h));

    if (done) begin
      // past the last row: byte ignored
    end else if (phase == rsd_pkg::PH_LITERAL && run_rem != '0) begin
      e_write = 1'b1;
      n_rem   = rem1;
      if (col + COL_W'(1) >= COL_W'(img_w)) begin
        er      = 1'b1;
        n_phase = rsd_pkg::PH_OPCODE;
        n_rem   = '0;
      end else begin
        n_col = col + COL_W'(1);
        if (rem1 == '0) n_phase = rsd_pkg::PH_OPCODE;
      end
    end else if (phase == rsd_pkg::PH_COLOUR) begin
      colour_step = 1'b1;
      if (ce < COL_W'(img_w)) begin
        e_write = 1'b1;
        e_col   = ce;
        n_rem   = rem1;
        n_col   = colstep;
        e_last  = (rem1 == '0) || (next_ce >= COL_W'(img_w));
        if (e_last) begin
          er      = (colstep >= COL_W'(img_w)) || (rem1 != '0);
          n_phase = rsd_pkg::PH_OPCODE;
          n_rem   = '0;
        end
      end else begin
        // sparse run starting on the last column writes nothing
        er      = 1'b1;
        n_phase = rsd_pkg::PH_OPCODE;
        n_rem   = '0;
      end
    end else begin
      n_phase = rsd_pkg::PH_OPCODE;
      case (rsd_pkg::mode_t'(in_byte[7:6]))
        rsd_pkg::MODE_SKIP: begin
          if (skip_sum >= COL_W'(img_w)) er = 1'b1;
          else n_col = skip_sum;
        end
        rsd_pkg::MODE_LITERAL: begin
          n_phase = rsd_pkg::PH_LITERAL;
          n_rem   = count;
        end
        default: begin
          n_phase = rsd_pkg::PH_COLOUR;
          n_mode  = rsd_pkg::mode_t'(in_byte[7:6]);
          n_rem   = count;
        end
      endcase
    end

    if (er) begin
      n_col = '0;
      if (row_inc >= ROW_W'(img_h)) begin
        n_row  = ROW_W'(img_h);
        n_done = 1'b1;
      end else begin
        n_row = row_inc;
      end
    end

    e_done = (colour_step && !e_last) ? run_done_pred : n_done;
  end

  assign addr_full     = 32'(row) * 32'(stride) + 32'(e_col);
  assign sts.step_last = e_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= rsd_pkg::PH_OPCODE;
      run_mode <= rsd_pkg::MODE_FILL;
      run_rem  <= '0;
      col      <= '0;
      row      <= '0;
      done     <= 1'b0;
    end else if (cmd.prep) begin
      phase    <= p_phase;
      run_mode <= p_mode;
      run_rem  <= p_rem;
      col      <= p_col;
      row      <= p_row;
      done     <= p_done;
    end else if (cmd.exec) begin
      phase    <= n_phase;
      run_mode <= n_mode;
      run_rem  <= n_rem;
      col      <= n_col;
      row      <= n_row;
      done     <= n_done;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_byte <= byte_in;
      in_soi  <= start_of_image;
    end
    if (cmd.exec) begin
      write_valid   <= e_write;
      pixel_address <= e_write ? addr_full[rsd_pkg::ADDR_W-1:0] : '0;
      pixel_value   <= e_write ? in_byte : '0;
      image_done    <= e_done;
      last_of_run   <= e_last;
    end
  end

endmodule

### hw/rtl/rle_sprite_row_decoder.sv
// ----------------------------------------------------------------------------
// rle_sprite_row_decoder
// Run-length sprite decoder: compressed bytes in, pixel writes out.
// ----------------------------------------------------------------------------
// Each accepted byte gives one or more results on the output stream; the last
// result of a byte carries tlast. Each byte gets a prepare step (row and image
// end checks), then execute steps that decode into the output register: one
// for an opcode, literal or ignored byte, one per write for a fill or sparse
// run (one if it writes nothing), as the output register takes one write per
// cycle while the output is not stalled. The next byte is taken in the cycle
// the previous one finishes. A held result on the output side holds the decode
// step and with it intake, so an output stall stretches the byte by its length.
// Write address is row * row_stride + column, wrapped to 16 bits.
module rle_sprite_row_decoder #(
  parameter int MAX_DIM = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  // input stream
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // [7:0] byte_in
  input  logic [0:0]                   s_tuser,   // [0] start_of_image
  // output stream
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [23:0]                  m_tdata,   // [15:0] pixel_address, [23:16] pixel_value
  output logic [1:0]                   m_tuser,   // [0] write_valid, [1] image_done
  output logic                         m_tlast,   // last_of_run
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rsd_pkg::PADDR_W-1:0]  paddr,
  input  logic [rsd_pkg::PDATA_W-1:0]  pwdata,
  output logic [rsd_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);

  logic [DIM_W-1:0]             img_w;
  logic [DIM_W-1:0]             img_h;
  logic [rsd_pkg::STRIDE_W-1:0] stride;
  rsd_pkg::dp_cmd_t             cmd;
  rsd_pkg::dp_sts_t             sts;
  logic                         write_valid;
  logic [rsd_pkg::ADDR_W-1:0]   pixel_address;
  logic [rsd_pkg::BYTE_W-1:0]   pixel_value;
  logic                         image_done;
  logic                         last_of_run;

  rsd_cfg #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .img_w   (img_w),
    .img_h   (img_h),
    .stride  (stride)
  );

  rsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  rsd_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .byte_in        (s_tdata),
    .start_of_image (s_tuser[0]),
    .img_w          (img_w),
    .img_h          (img_h),
    .stride         (stride),
    .write_valid    (write_valid),
    .pixel_address  (pixel_address),
    .pixel_value    (pixel_value),
    .image_done     (image_done),
    .last_of_run    (last_of_run)
  );

  assign m_tdata = {pixel_value, pixel_address};
  assign m_tuser = {image_done, write_valid};
  assign m_tlast = last_of_run;

endmodule

### hw/rtl/rsd_checker.sv
// ----------------------------------------------------------------------------
// rsd_checker
// Port-level checks for the sprite row decoder, bound to the top level.
// ----------------------------------------------------------------------------
module rsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output transfer changed while stalled");

  // a result without a write carries zero address and value
  a_nowrite_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == 24'd0)
    else $error("non-write result with nonzero payload");

  // a byte that writes nothing gives exactly one result
  a_nowrite_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast)
    else $error("non-write result not marked last");

  // out of reset: nothing pending, input open
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("state not cleared by reset");

endmodule

bind rle_sprite_row_decoder rsd_checker u_rsd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

### bench/rle_sprite_row_decoder_test.sv
// ----------------------------------------------------------------------------
// rle_sprite_row_decoder_test
// Self-checking bench for the run-length sprite row decoder. A directed table
// walks every opcode mode, row cut-off and image restart. Random opcode runs
// then follow under several register settings and handshake idle patterns.
// Every output transfer is checked: typed table rows against their table entry,
// all other bytes against a behavioral decoder kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rle_sprite_row_decoder_test;

  localparam int DIM_LIMIT      = 64;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int N_DIRECTED     = 23;
  localparam int N_SETTINGS     = 8;

  typedef struct packed {
    logic        wr;
    logic [15:0] addr;
    logic [7:0]  val;
    logic        done;
    logic        last;
  } pix_result_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        soi;
    logic        typed;
    pix_result_t res;
  } dir_row_t;

  typedef struct packed {
    logic [6:0]  width;
    logic [6:0]  height;
    logic [10:0] stride;
    logic [7:0]  quota;
  } setting_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [rsd_pkg::PADDR_W-1:0] paddr = '0;
  logic [rsd_pkg::PDATA_W-1:0] pwdata = '0;
  logic [rsd_pkg::PDATA_W-1:0] prdata;
  logic        pready;

  rle_sprite_row_decoder #(.MAX_DIM(DIM_LIMIT)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // directed rows under the reset setting 64 x 64, stride 64
  dir_row_t directed_rows [N_DIRECTED] = '{
    '{8'h00, 1'b1, 1'b1, '{1'b0, 16'h0000, 8'h00, 1'b0, 1'b1}},  // fill 1
    '{8'hFF, 1'b0, 1'b1, '{1'b1, 16'h0000, 8'hFF, 1'b0, 1'b1}},  // its colour
    '{8'hC0, 1'b0, 1'b1, '{1'b0, 16'h0000, 8'h00, 1'b0, 1'b1}},  // skip 1
    '{8'h41, 1'b0, 1'b1, '{1'b0, 16'h0000, 8'h00, 1'b0, 1'b1}},  // sparse 2
    '{8'hAA, 1'b0, 1'b0, '0},
    '{8'h82, 1'b0, 1'b1, '{1'b0, 16'h0000, 8'h00, 1'b0, 1'b1}},  // literal 3
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h7F, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'hF4, 1'b0, 1'b1, '{1'b0, 16'h0000, 8'h00, 1'b0, 1'b1}},  // skip to col 62
    '{8'h83, 1'b0, 1'b1, '{1'b0, 16'h0000, 8'h00, 1'b0, 1'b1}},  // literal 4
    '{8'h11, 1'b0, 1'b0, '0},
    '{8'h22, 1'b0, 1'b0, '0},                                    // row end
    '{8'h3F, 1'b0, 1'b1, '{1'b0, 16'h0000, 8'h00, 1'b0, 1'b1}},  // cut literal as fill 64
    '{8'h5A, 1'b0, 1'b0, '0},                                    // full row of writes
    '{8'h7F, 1'b0, 1'b1, '{1'b0, 16'h0000, 8'h00, 1'b0, 1'b1}},  // sparse 64
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b1, '{1'b0, 16'h0000, 8'h00, 1'b0, 1'b1}},  // skip exactly to row end
    '{8'hFE, 1'b1, 1'b1, '{1'b0, 16'h0000, 8'h00, 1'b0, 1'b1}},  // restart, skip 63
    '{8'hC1, 1'b0, 1'b1, '{1'b0, 16'h0000, 8'h00, 1'b0, 1'b1}},  // skip past row end
    '{8'h81, 1'b0, 1'b1, '{1'b0, 16'h0000, 8'h00, 1'b0, 1'b1}},  // literal 2
    '{8'h00, 1'b1, 1'b1, '{1'b0, 16'h0000, 8'h00, 1'b0, 1'b1}},  // restart drops literal
    '{8'h00, 1'b0, 1'b1, '{1'b1, 16'h0000, 8'h00, 1'b0, 1'b1}}
  };

  // quota counts input bytes per setting
  setting_t settings [N_SETTINGS] = '{
    '{7'd8,   7'd4,   11'd1000, 8'd26},
    '{7'd1,   7'd1,   11'd1,    8'd24},
    '{7'd0,   7'd0,   11'd0,    8'd24},
    '{7'd64,  7'd64,  11'd1024, 8'd26},
    '{7'd127, 7'd127, 11'd2047, 8'd24},
    '{7'd13,  7'd5,   11'd37,   8'd26},
    '{7'd1,   7'd64,  11'd2047, 8'd36},
    '{7'd64,  7'd2,   11'd512,  8'd22}
  };

  // register copies and decoder state
  logic [6:0]  width_reg  = rsd_pkg::WIDTH_RST;
  logic [6:0]  height_reg = rsd_pkg::HEIGHT_RST;
  logic [10:0] stride_reg = rsd_pkg::STRIDE_RST;
  rsd_pkg::phase_t dec_phase;
  rsd_pkg::mode_t  dec_mode;
  int unsigned run_left;
  int unsigned dec_col;
  int unsigned dec_row;
  bit          image_complete;

  pix_result_t pixel_burst [$];
  pix_result_t expected_pixels [$];

  int mismatches    = 0;
  int bytes_sent    = 0;
  int bytes_decoded = 0;
  int phase_sent    = 0;
  int results_seen  = 0;
  int writes_seen   = 0;
  int idle_cycles   = 0;
  int snd_idle_pct  = 0;
  int rcv_idle_pct  = 0;

  function automatic int unsigned dim_eff(input logic [6:0] v);
    if (v == 0) return 1;
    if (v > DIM_LIMIT) return DIM_LIMIT;
    return 32'(v);
  endfunction

  function automatic void next_row(input int unsigned h);
    dec_col = 0;
    dec_row = dec_row + 1;
    if (dec_row >= h) begin
      dec_row = h;
      image_complete = 1'b1;
    end
  endfunction

  function automatic void emit_pixel(input logic [7:0] v);
    logic [31:0] a;
    a = dec_row * stride_reg + dec_col;
    pixel_burst.push_back('{1'b1, a[15:0], v, 1'b0, 1'b0});
  endfunction

  // expected transfers for one byte, left in pixel_burst
  task automatic decode_byte(input logic [7:0] b, input logic soi, output bit ignored);
    int unsigned w;
    int unsigned h;
    int unsigned cnt;
    int unsigned i;
    rsd_pkg::mode_t md;
    w = dim_eff(width_reg);
    h = dim_eff(height_reg);
    pixel_burst.delete();
    if (soi) begin
      dec_row = 0;
      dec_col = 0;
      dec_phase = rsd_pkg::PH_OPCODE;
      dec_mode = rsd_pkg::MODE_FILL;
      run_left = 0;
      image_complete = 1'b0;
    end
    if (!image_complete && dec_row >= h) begin
      dec_row = h;
      image_complete = 1'b1;
    end
    // width lowered under the cursor ends the row and drops the run
    if (!image_complete && dec_col >= w) begin
      next_row(h);
      dec_phase = rsd_pkg::PH_OPCODE;
      run_left = 0;
    end
    ignored = image_complete;
    if (!image_complete) begin
      if (dec_phase == rsd_pkg::PH_LITERAL && run_left != 0) begin
        emit_pixel(b);
        dec_col++;
        run_left--;
        if (dec_col >= w) begin
          next_row(h);
          dec_phase = rsd_pkg::PH_OPCODE;
          run_left = 0;
        end else if (run_left == 0) begin
          dec_phase = rsd_pkg::PH_OPCODE;
        end
      end else if (dec_phase == rsd_pkg::PH_COLOUR) begin
        for (i = 0; i < run_left && dec_col < w; i++) begin
          if (dec_mode == rsd_pkg::MODE_SPARSE) begin
            dec_col++;
            if (dec_col < w) emit_pixel(b);
            dec_col++;
          end else begin
            emit_pixel(b);
            dec_col++;
          end
        end
        if (dec_col >= w) next_row(h);
        dec_phase = rsd_pkg::PH_OPCODE;
        run_left = 0;
      end else begin
        cnt = (b & rsd_pkg::COUNT_MASK) + 1;
        md = rsd_pkg::mode_t'(b[7:6]);
        dec_phase = rsd_pkg::PH_OPCODE;
        case (md)
          rsd_pkg::MODE_SKIP: begin
            dec_col += cnt;
            if (dec_col >= w) next_row(h);
          end
          rsd_pkg::MODE_LITERAL: begin
            dec_phase = rsd_pkg::PH_LITERAL;
            run_left = cnt;
          end
          default: begin
            dec_phase = rsd_pkg::PH_COLOUR;
            dec_mode = md;
            run_left = cnt;
          end
        endcase
      end
    end
    if (pixel_burst.size() == 0) pixel_burst.push_back('0);
    foreach (pixel_burst[k]) begin
      pixel_burst[k].done = image_complete;
      pixel_burst[k].last = (k == pixel_burst.size() - 1);
    end
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [rsd_pkg::PDATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      rsd_pkg::REG_IMAGE_WIDTH:  width_reg = val[6:0];
      rsd_pkg::REG_IMAGE_HEIGHT: height_reg = val[6:0];
      rsd_pkg::REG_ROW_STRIDE:   stride_reg = val[10:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic soi, input bit typed,
                           input pix_result_t typed_res);
    bit ignored;
    while ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= soi;
    do @(posedge clk); while (!s_tready);
    decode_byte(b, soi, ignored);
    if (typed) expected_pixels.push_back(typed_res);
    else foreach (pixel_burst[k]) expected_pixels.push_back(pixel_burst[k]);
    bytes_sent++;
    phase_sent++;
    if (!ignored) bytes_decoded++;
  endtask

  function automatic logic [7:0] random_pixel();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // one well-formed opcode with its operands, or now and then a stray byte
  task automatic random_chunk();
    logic        soi;
    logic [5:0]  cnt;
    logic [1:0]  md;
    int unsigned k;
    if ($urandom_range(9) == 0) begin
      push_byte(8'($urandom_range(255)), $urandom_range(7) == 0, 1'b0, '0);
      return;
    end
    soi = image_complete ? ($urandom_range(3) != 0) : ($urandom_range(29) == 0);
    cnt = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(7));
    md = 2'($urandom_range(3));
    push_byte({md, cnt}, soi, 1'b0, '0);
    if (md == rsd_pkg::MODE_LITERAL) begin
      for (k = 0; k <= cnt; k++) push_byte(random_pixel(), 1'b0, 1'b0, '0);
    end else if (md != rsd_pkg::MODE_SKIP) begin
      push_byte(random_pixel(), 1'b0, 1'b0, '0);
    end
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) m_tready <= ($urandom_range(99) >= rcv_idle_pct);

  always @(posedge clk) begin : check_output
    pix_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (m_tuser[0]) writes_seen++;
      if (expected_pixels.size() == 0) begin
        $error("output transfer with no expected result: addr 0x%0h value 0x%0h",
               m_tdata[15:0], m_tdata[23:16]);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("write_valid", 32'(want.wr), 32'(m_tuser[0]));
        check_field("pixel_address", 32'(want.addr), 32'(m_tdata[15:0]));
        check_field("pixel_value", 32'(want.val), 32'(m_tdata[23:16]));
        check_field("image_done", 32'(want.done), 32'(m_tuser[1]));
        check_field("last_of_run", 32'(want.last), 32'(m_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    int ph;
    dec_phase = rsd_pkg::PH_OPCODE;
    dec_mode = rsd_pkg::MODE_FILL;
    run_left = 0;
    dec_col = 0;
    dec_row = 0;
    image_complete = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      push_byte(directed_rows[i].data, directed_rows[i].soi, directed_rows[i].typed,
                directed_rows[i].res);
    wait_drain();

    // no restart between settings, so a smaller width or height lands mid-image
    for (ph = 0; ph < N_SETTINGS; ph++) begin
      case (ph % 4)
        0: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  end
        1: begin snd_idle_pct = 62; rcv_idle_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_idle_pct = 62; end
        default: begin snd_idle_pct = 35; rcv_idle_pct = 35; end
      endcase
      reg_write(rsd_pkg::REG_IMAGE_WIDTH, rsd_pkg::PDATA_W'(settings[ph].width));
      reg_write(rsd_pkg::REG_IMAGE_HEIGHT, rsd_pkg::PDATA_W'(settings[ph].height));
      reg_write(rsd_pkg::REG_ROW_STRIDE, rsd_pkg::PDATA_W'(settings[ph].stride));
      phase_sent = 0;
      while (phase_sent < settings[ph].quota) random_chunk();
      wait_drain();
    end

    repeat (20) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      $error("%0d expected results never arrived", expected_pixels.size());
      mismatches++;
    end
    $display("covered %0d input bytes (%0d decoded) over %0d register settings",
             bytes_sent, bytes_decoded, N_SETTINGS + 1);
    $display("checked %0d output transfers, %0d pixel writes, four idle patterns",
             results_seen, writes_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/rsd_pkg.sv
hw/rtl/rsd_cfg.sv
hw/rtl/rsd_ctrl.sv
hw/rtl/rsd_dp.sv
hw/rtl/rle_sprite_row_decoder.sv
hw/rtl/rsd_checker.sv
bench/rle_sprite_row_decoder_test.sv
